/* src/cpg_pkg.sv */
// Shared constants for the cation-pi geometry check: field widths,
// configuration register indexes and reset values, multiplier chunk size.
// No dependencies.
`default_nettype none

package cpg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ORIENT_BITS    = 16;
  localparam int DIST_BITS      = 15;
  localparam int COS_BITS       = 16;
  localparam int OSQ_BITS       = 32;   // |o|^2 of a 16 bit vector
  localparam int ANGLE_SHIFT    = 30;   // Q1.15 squared against Q.22 squared
  localparam int MUL_CHUNK      = 24;   // partial product operand width

  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS  = 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DIST   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COS_MAX    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AROM_FIRST = 2'd3;

  localparam logic [DIST_BITS-1:0] MIN_DIST_RST   = 15'd896;
  localparam logic [DIST_BITS-1:0] MAX_DIST_RST   = 15'd1408;
  localparam logic [COS_BITS-1:0]  COS_MAX_RST    = 16'd23170;
  localparam logic                 AROM_FIRST_RST = 1'b1;

endpackage

`default_nettype wire

/* src/cpg_mul.sv */
// Two-stage unsigned multiplier: operands cut into MUL_CHUNK wide pieces,
// partial products registered, then shifted and summed into the result register.
// Depends on cpg_pkg.
`default_nettype none

module cpg_mul import cpg_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic [AW+BW-1:0]   p
);

  localparam int KA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int KB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int SW = (KA + KB) * MUL_CHUNK;

  logic [KA*MUL_CHUNK-1:0]  a_ext;
  logic [KB*MUL_CHUNK-1:0]  b_ext;
  logic [2*MUL_CHUNK-1:0]   pp_nxt [KA][KB];
  logic [2*MUL_CHUNK-1:0]   pp_r   [KA][KB];
  logic [SW-1:0]            sum_nxt;
  logic [AW+BW-1:0]         p_r;

  assign a_ext = (KA*MUL_CHUNK)'(a);
  assign b_ext = (KB*MUL_CHUNK)'(b);

  always_comb begin
    for (int i = 0; i < KA; i++) begin
      for (int j = 0; j < KB; j++) begin
        pp_nxt[i][j] = (2*MUL_CHUNK)'(a_ext[i*MUL_CHUNK +: MUL_CHUNK]) *
                       (2*MUL_CHUNK)'(b_ext[j*MUL_CHUNK +: MUL_CHUNK]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < KA; i++) begin
      for (int j = 0; j < KB; j++) begin
        sum_nxt = sum_nxt + (SW'(pp_r[i][j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      p_r  <= (AW+BW)'(sum_nxt);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* src/cation_pi_geometry_check.sv */
// Cation-pi geometry check, top level: ten-stage pipeline from two feature
// positions and an optional ring normal to a match / angle_ok pair.
// Depends on cpg_pkg and cpg_mul.
//
// Usage:
//   in_*  : one transaction per feature pair. in_tdata holds first_x/y/z,
//           second_x/y/z (COORD_BITS each, signed Q8.8) then orient_x/y/z
//           (16 bit signed Q1.14), lowest bits first. in_tuser is has_orientation.
//   out_* : one transaction per pair, out_tdata[0] match, [1] angle_ok.
//   cfg_* : register writes, index 0 min_distance, 1 max_distance,
//           2 cos_max_angle, 3 aromatic_first; always ready. Write only while idle.
// One pair is taken every cycle while the receiver does not hold off out_tready.
// The depth is set by the chain of squares, dot product,
// and two rounds of partial-product multipliers (|o|^2 * cos^2, then * |v|^2).
// When the receiver holds off out_tready with a result waiting, the whole
// pipeline freezes and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// distances 3.5 and 5.5 angstroms, cos 45 degrees, and first feature aromatic.
`default_nettype none

module cation_pi_geometry_check import cpg_pkg::*; #(
  parameter int  COORD_BITS = COORD_BITS_DEF,
  localparam int IN_DW = ((6*COORD_BITS + 3*ORIENT_BITS + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // orient_x, orient_y, orient_z, zero fill
  input  wire logic [IN_DW-1:0]         in_tdata,
  input  wire logic                     in_tuser,   // has_orientation
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0]      out_tdata,  // match, angle_ok, zero fill
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int VW    = COORD_BITS + 1;
  localparam int LENW  = 2 * VW;
  localparam int DPW   = ORIENT_BITS + VW;
  localparam int DOTW  = DPW + 2;
  localparam int DMW   = DPW;
  localparam int DSQW  = 2 * DMW;
  localparam int CSQW  = 2 * COS_BITS;
  localparam int CLW   = CSQW + OSQ_BITS;
  localparam int DSQ2W = 2 * DIST_BITS;
  localparam int RNGW  = DSQ2W + OSQ_BITS;
  localparam int RHSW  = CLW + LENW;
  localparam int RCW   = (DSQW > RNGW) ? DSQW : RNGW;
  localparam int LCW   = (LENW > DSQ2W) ? LENW : DSQ2W;

  // configuration
  logic [DIST_BITS-1:0] min_dist_r, max_dist_r;
  logic [COS_BITS-1:0]  cos_max_r;
  logic                 arom_first_r;
  logic [DSQ2W-1:0]     min_sq_r, max_sq_r;
  logic [CSQW-1:0]      cos_sq_r;

  logic adv;

  // stage 1
  logic signed [COORD_BITS-1:0]  first_c [3];
  logic signed [COORD_BITS-1:0]  second_c [3];
  logic signed [ORIENT_BITS-1:0] orient_c [3];
  logic signed [COORD_BITS-1:0]  f1_r [3];
  logic signed [COORD_BITS-1:0]  s1_r [3];
  logic signed [ORIENT_BITS-1:0] o1_r [3];
  logic                          has1_r, val1_r;
  // stage 2
  logic signed [VW-1:0]          v2_nxt [3];
  logic signed [VW-1:0]          v2_r [3];
  logic [VW-1:0]                 vm2_nxt [3];
  logic [VW-1:0]                 vm2_r [3];
  logic signed [ORIENT_BITS-1:0] o2_r [3];
  logic                          has2_r, val2_r;
  // stage 3
  logic [LENW-1:0]               vsq3_nxt [3];
  logic [LENW-1:0]               vsq3_r [3];
  logic [OSQ_BITS-1:0]           osq3_nxt [3];
  logic [OSQ_BITS-1:0]           osq3_r [3];
  logic signed [DPW-1:0]         dp3_nxt [3];
  logic signed [DPW-1:0]         dp3_r [3];
  logic                          has3_r, val3_r;
  // stage 4
  logic [LENW-1:0]               lenv4_r;
  logic [OSQ_BITS-1:0]           lo4_r;
  logic signed [DOTW-1:0]        dot4_r;
  logic                          has4_r, val4_r;
  // stage 5
  logic signed [DOTW-1:0]        dneg;
  logic [DMW-1:0]                dmag5_nxt, dmag5_r;
  logic [LENW-1:0]               lenv5_r;
  logic [OSQ_BITS-1:0]           lo5_r;
  logic                          nz5_r, has5_r, val5_r;
  // stages 6, 7
  logic [LENW-1:0]               lenv6_r, lenv7_r;
  logic                          nz6_r, nz7_r, has6_r, has7_r, val6_r, val7_r;
  logic [DSQW-1:0]               dsq7;
  logic [CLW-1:0]                cl7;
  logic [RNGW-1:0]               mnlo7, mxlo7;
  // stages 8, 9
  logic                          rng8_nxt;
  logic [DSQW-1:0]               dsq8_r, dsq9_r;
  logic                          rng8_r, rng9_r, nz8_r, nz9_r;
  logic                          has8_r, has9_r, val8_r, val9_r;
  logic [RHSW-1:0]               rhs9;
  // output
  logic                          angle_nxt, match_nxt;
  logic                          angle_r, match_r, out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r   <= MIN_DIST_RST;
      max_dist_r   <= MAX_DIST_RST;
      cos_max_r    <= COS_MAX_RST;
      arom_first_r <= AROM_FIRST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_DIST:   min_dist_r   <= cfg_data[DIST_BITS-1:0];
        CFG_MAX_DIST:   max_dist_r   <= cfg_data[DIST_BITS-1:0];
        CFG_COS_MAX:    cos_max_r    <= cfg_data[COS_BITS-1:0];
        CFG_AROM_FIRST: arom_first_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    min_sq_r <= DSQ2W'(min_dist_r) * DSQ2W'(min_dist_r);
    max_sq_r <= DSQ2W'(max_dist_r) * DSQ2W'(max_dist_r);
    cos_sq_r <= CSQW'(cos_max_r) * CSQW'(cos_max_r);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      first_c[k]  = in_tdata[k*COORD_BITS +: COORD_BITS];
      second_c[k] = in_tdata[(3+k)*COORD_BITS +: COORD_BITS];
      orient_c[k] = in_tdata[6*COORD_BITS + k*ORIENT_BITS +: ORIENT_BITS];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v2_nxt[k]  = arom_first_r ? (VW'(f1_r[k]) - VW'(s1_r[k]))
                                : (VW'(s1_r[k]) - VW'(f1_r[k]));
      vm2_nxt[k] = v2_nxt[k][VW-1] ? -v2_nxt[k] : v2_nxt[k];
      vsq3_nxt[k] = LENW'(vm2_r[k]) * LENW'(vm2_r[k]);
      osq3_nxt[k] = OSQ_BITS'(o2_r[k]) * OSQ_BITS'(o2_r[k]);
      dp3_nxt[k]  = DPW'(o2_r[k]) * DPW'(v2_r[k]);
    end
  end

  assign dneg      = -dot4_r;
  assign dmag5_nxt = dot4_r[DOTW-1] ? dneg[DMW-1:0] : dot4_r[DMW-1:0];

  assign rng8_nxt = has7_r ?
      (RCW'(dsq7) >= RCW'(mnlo7) && RCW'(dsq7) <= RCW'(mxlo7)) :
      (LCW'(lenv7_r) >= LCW'(min_sq_r) && LCW'(lenv7_r) <= LCW'(max_sq_r));

  assign angle_nxt = !has9_r ||
      (nz9_r && (RHSW'({dsq9_r, {ANGLE_SHIFT{1'b0}}}) >= rhs9));
  assign match_nxt = angle_nxt && rng9_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r      <= 1'b0;
      val2_r      <= 1'b0;
      val3_r      <= 1'b0;
      val4_r      <= 1'b0;
      val5_r      <= 1'b0;
      val6_r      <= 1'b0;
      val7_r      <= 1'b0;
      val8_r      <= 1'b0;
      val9_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      val1_r      <= in_tvalid;
      val2_r      <= val1_r;
      val3_r      <= val2_r;
      val4_r      <= val3_r;
      val5_r      <= val4_r;
      val6_r      <= val5_r;
      val7_r      <= val6_r;
      val8_r      <= val7_r;
      val9_r      <= val8_r;
      out_valid_r <= val9_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        f1_r[k]   <= first_c[k];
        s1_r[k]   <= second_c[k];
        o1_r[k]   <= orient_c[k];
        v2_r[k]   <= v2_nxt[k];
        vm2_r[k]  <= vm2_nxt[k];
        o2_r[k]   <= o1_r[k];
        vsq3_r[k] <= vsq3_nxt[k];
        osq3_r[k] <= osq3_nxt[k];
        dp3_r[k]  <= dp3_nxt[k];
      end
      has1_r  <= in_tuser;
      has2_r  <= has1_r;
      has3_r  <= has2_r;

      lenv4_r <= vsq3_r[0] + vsq3_r[1] + vsq3_r[2];
      lo4_r   <= osq3_r[0] + osq3_r[1] + osq3_r[2];
      dot4_r  <= DOTW'(dp3_r[0]) + DOTW'(dp3_r[1]) + DOTW'(dp3_r[2]);
      has4_r  <= has3_r;

      dmag5_r <= dmag5_nxt;
      lenv5_r <= lenv4_r;
      lo5_r   <= lo4_r;
      nz5_r   <= (lenv4_r != '0) && (lo4_r != '0);
      has5_r  <= has4_r;

      lenv6_r <= lenv5_r;
      nz6_r   <= nz5_r;
      has6_r  <= has5_r;
      lenv7_r <= lenv6_r;
      nz7_r   <= nz6_r;
      has7_r  <= has6_r;

      dsq8_r  <= dsq7;
      rng8_r  <= rng8_nxt;
      nz8_r   <= nz7_r;
      has8_r  <= has7_r;
      dsq9_r  <= dsq8_r;
      rng9_r  <= rng8_r;
      nz9_r   <= nz8_r;
      has9_r  <= has8_r;

      angle_r <= angle_nxt;
      match_r <= match_nxt;
    end
  end

  // |o.v|^2
  cpg_mul #(.AW(DMW), .BW(DMW)) u_dsq (
    .clk(clk), .en(adv), .a(dmag5_r), .b(dmag5_r), .p(dsq7)
  );

  // cos^2 * |o|^2
  cpg_mul #(.AW(CSQW), .BW(OSQ_BITS)) u_cl (
    .clk(clk), .en(adv), .a(cos_sq_r), .b(lo5_r), .p(cl7)
  );

  // min^2 * |o|^2, max^2 * |o|^2
  cpg_mul #(.AW(DSQ2W), .BW(OSQ_BITS)) u_mnlo (
    .clk(clk), .en(adv), .a(min_sq_r), .b(lo5_r), .p(mnlo7)
  );

  cpg_mul #(.AW(DSQ2W), .BW(OSQ_BITS)) u_mxlo (
    .clk(clk), .en(adv), .a(max_sq_r), .b(lo5_r), .p(mxlo7)
  );

  // cos^2 * |o|^2 * |v|^2
  cpg_mul #(.AW(CLW), .BW(LENW)) u_rhs (
    .clk(clk), .en(adv), .a(cl7), .b(lenv7_r), .p(rhs9)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-2){1'b0}}, angle_r, match_r};

  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv && val9_r |=> out_tvalid)
    else $error("result lost between last stage and output register");

  a_no_orient_angle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && val9_r && !has9_r |=> out_tdata[1])
    else $error("angle_ok low without orientation");

  a_zero_len_fails: assert property (@(posedge clk) disable iff (!rst_n)
    adv && val9_r && has9_r && !nz9_r |=> !out_tdata[1] && !out_tdata[0])
    else $error("zero-length vector passed angle test");

  a_match_needs_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1] || !out_tdata[0]))
    else $error("match without angle_ok");

endmodule

`default_nettype wire

/* tb/tb_cation_pi_geometry_check.sv */
// Self-checking testbench for cation_pi_geometry_check: directed boundary pairs, then
// random pair streams under several register settings, with random back-pressure on all but the last two.
// Depends on cpg_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_cation_pi_geometry_check import cpg_pkg::*;;

  localparam int IN_W    = ((6*COORD_BITS_DEF + 3*ORIENT_BITS + 7) / 8) * 8;
  localparam int LATENCY = 10;

  typedef struct {
    logic signed [COORD_BITS_DEF-1:0] first_x, first_y, first_z;
    logic signed [COORD_BITS_DEF-1:0] second_x, second_y, second_z;
    logic                             has_orient;
    logic signed [ORIENT_BITS-1:0]    orient_x, orient_y, orient_z;
  } geom_pair_t;

  typedef struct {
    logic match;
    logic angle_ok;
  } geom_result_t;

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata   = '0;
  logic                     in_tuser   = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = CFG_MIN_DIST;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

  // register shadow
  logic [DIST_BITS-1:0] dist_min   = MIN_DIST_RST;
  logic [DIST_BITS-1:0] dist_max   = MAX_DIST_RST;
  logic [COS_BITS-1:0]  cos_max    = COS_MAX_RST;
  logic                 arom_first = AROM_FIRST_RST;

  geom_pair_t   pending_pairs[$];
  geom_result_t expected_results[$];
  geom_pair_t   in_flight;
  bit           in_xfer      = 1'b0;
  bit           hold_in      = 1'b0;
  int           in_idle_pct  = 0;
  int           out_idle_pct = 0;
  int           mismatch_count = 0;

  cation_pi_geometry_check u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Exact squared-integer form of the distance, angle and projected distance tests.
  function automatic geom_result_t check_geometry(geom_pair_t p);
    longint       vx, vy, vz, ox, oy, oz, dot;
    logic [127:0] len_v, len_o, dot_sq, lim_lo, lim_hi, cos_sq;
    geom_result_t r;
    if (arom_first) begin
      vx = longint'(p.first_x) - longint'(p.second_x);
      vy = longint'(p.first_y) - longint'(p.second_y);
      vz = longint'(p.first_z) - longint'(p.second_z);
    end else begin
      vx = longint'(p.second_x) - longint'(p.first_x);
      vy = longint'(p.second_y) - longint'(p.first_y);
      vz = longint'(p.second_z) - longint'(p.first_z);
    end
    ox = longint'(p.orient_x);
    oy = longint'(p.orient_y);
    oz = longint'(p.orient_z);
    len_v  = 128'(vx*vx + vy*vy + vz*vz);
    lim_lo = 128'(dist_min) * 128'(dist_min);
    lim_hi = 128'(dist_max) * 128'(dist_max);
    r.angle_ok = 1'b1;
    if (!p.has_orient) begin
      r.match = (len_v >= lim_lo) && (len_v <= lim_hi);
    end else begin
      len_o  = 128'(ox*ox + oy*oy + oz*oz);
      dot    = ox*vx + oy*vy + oz*vz;
      dot_sq = 128'(dot < 0 ? -dot : dot);
      dot_sq = dot_sq * dot_sq;
      if (len_v == 0 || len_o == 0) begin
        r.angle_ok = 1'b0;
      end else begin
        cos_sq = 128'(cos_max) * 128'(cos_max);
        r.angle_ok = (dot_sq << ANGLE_SHIFT) >= cos_sq * len_o * len_v;
      end
      r.match = r.angle_ok && (dot_sq >= lim_lo * len_o) && (dot_sq <= lim_hi * len_o);
    end
    return r;
  endfunction

  // Mostly pairs with an offset of bounded span, half of those near the distance window,
  // orientation close to the offset; the rest is unconstrained noise or a zero offset.
  function automatic geom_pair_t random_pair();
    geom_pair_t p;
    int kind, span, peak, noise, i;
    int b[3];
    int d[3];
    int o[3];
    kind = $urandom_range(99);
    if (kind < 15) begin
      p.first_x  = COORD_BITS_DEF'($urandom);
      p.first_y  = COORD_BITS_DEF'($urandom);
      p.first_z  = COORD_BITS_DEF'($urandom);
      p.second_x = COORD_BITS_DEF'($urandom);
      p.second_y = COORD_BITS_DEF'($urandom);
      p.second_z = COORD_BITS_DEF'($urandom);
      p.orient_x = ORIENT_BITS'($urandom);
      p.orient_y = ORIENT_BITS'($urandom);
      p.orient_z = ORIENT_BITS'($urandom);
      p.has_orient = 1'($urandom_range(1));
      return p;
    end
    span = (kind < 60) ? int'(dist_max) + 96 : int'($urandom_range(4096, 64));
    if (span > 8000) span = 8000;
    peak = 0;
    for (i = 0; i < 3; i++) begin
      b[i] = int'($urandom_range(48000)) - 24000;
      d[i] = (kind < 20) ? 0 : int'($urandom_range(2*span)) - span;
      if (d[i] > peak) peak = d[i];
      if (-d[i] > peak) peak = -d[i];
    end
    case ($urandom_range(2))
      0: noise = 0;
      1: noise = 2000;
      default: noise = 8000;
    endcase
    for (i = 0; i < 3; i++) begin
      if ($urandom_range(19) == 0) o[i] = 0;
      else if (peak == 0) o[i] = int'($urandom_range(32767)) - 16384;
      else o[i] = d[i] * 16384 / peak + int'($urandom_range(2*noise)) - noise;
    end
    p.first_x  = COORD_BITS_DEF'(b[0]);
    p.first_y  = COORD_BITS_DEF'(b[1]);
    p.first_z  = COORD_BITS_DEF'(b[2]);
    p.second_x = COORD_BITS_DEF'(b[0] + d[0]);
    p.second_y = COORD_BITS_DEF'(b[1] + d[1]);
    p.second_z = COORD_BITS_DEF'(b[2] + d[2]);
    p.orient_x = ORIENT_BITS'(o[0]);
    p.orient_y = ORIENT_BITS'(o[1]);
    p.orient_z = ORIENT_BITS'(o[2]);
    p.has_orient = ($urandom_range(3) != 0);
    return p;
  endfunction

  task automatic add_pair(int fx, int fy, int fz, int sx, int sy, int sz,
                          bit ho, int ox, int oy, int oz);
    geom_pair_t p;
    p.first_x  = COORD_BITS_DEF'(fx);
    p.first_y  = COORD_BITS_DEF'(fy);
    p.first_z  = COORD_BITS_DEF'(fz);
    p.second_x = COORD_BITS_DEF'(sx);
    p.second_y = COORD_BITS_DEF'(sy);
    p.second_z = COORD_BITS_DEF'(sz);
    p.has_orient = ho;
    p.orient_x = ORIENT_BITS'(ox);
    p.orient_y = ORIENT_BITS'(oy);
    p.orient_z = ORIENT_BITS'(oz);
    pending_pairs.push_back(p);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_DIST:   dist_min   = val[DIST_BITS-1:0];
      CFG_MAX_DIST:   dist_max   = val[DIST_BITS-1:0];
      CFG_COS_MAX:    cos_max    = val[COS_BITS-1:0];
      CFG_AROM_FIRST: arom_first = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (hold_in || pending_pairs.size() == 0 || $urandom_range(99) < in_idle_pct) begin
        in_tvalid <= 1'b0;
      end else begin
        in_flight = pending_pairs.pop_front();
        in_tdata  <= {in_flight.orient_z, in_flight.orient_y, in_flight.orient_x,
                      in_flight.second_z, in_flight.second_y, in_flight.second_x,
                      in_flight.first_z, in_flight.first_y, in_flight.first_x};
        in_tuser  <= in_flight.has_orient;
        in_tvalid <= 1'b1;
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    geom_result_t want;
    in_xfer = rst_n && in_tvalid && in_tready;
    if (in_xfer) expected_results.push_back(check_geometry(in_flight));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, got match %b angle_ok %b",
                 $time, out_tdata[0], out_tdata[1]);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.match || out_tdata[1] !== want.angle_ok) begin
          $display("%0t: mismatch, expected match %b angle_ok %b, got match %b angle_ok %b",
                   $time, want.match, want.angle_ok, out_tdata[0], out_tdata[1]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int s, k;
    int mn, mx, cs, af;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: 3.5 to 5.5 A, cos 45 deg, first aromatic
    in_idle_pct  = 27;
    out_idle_pct = 45;
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0, 1, 16384, 0, 0);
    add_pair(1024, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_pair(896, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(895, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 1408, 0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 1409, 0, 0, 0, 0, 0, 0, 0);
    add_pair(1024, 0, 0, 0, 0, 0, 1, 16384, 0, 0);
    add_pair(1024, 0, 0, 0, 0, 0, 1, 0, 16384, 0);
    add_pair(1024, 1024, 0, 0, 0, 0, 1, 16384, 0, 0);
    add_pair(768, 768, 0, 0, 0, 0, 1, 16384, 0, 0);
    add_pair(-1024, 0, 0, 0, 0, 0, 1, 16384, 0, 0);
    add_pair(0, 0, 0, 1024, 0, 0, 1, -16384, 0, 0);
    add_pair(32767, 32767, 32767, -32768, -32768, -32768, 1, -32768, -32768, -32768);
    add_pair(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0, 0);
    add_pair(-32768, -32768, -32768, 32767, 32767, 32767, 1, 32767, 32767, 32767);
    add_pair(1024, 0, 0, 0, 0, 0, 0, -1, -1, -1);
    add_pair(20000, -20000, 5000, 19000, -20500, 4000, 1, 12000, -6000, 11000);
    add_pair(-1, -1, -1, 0, 0, 0, 1, -1, -1, -1);
    wait_drained();

    for (s = 0; s < 6; s++) begin
      case (s)
        0: begin mn = 896;     mx = 1408;    cs = 23170; af = 1; end
        1: begin mn = 0;       mx = 32767;   cs = 0;     af = 0; end
        2: begin mn = 32767;   mx = 32767;   cs = 32768; af = 1; end
        3: begin mn = 2000;    mx = 1000;    cs = 65535; af = 0; end
        4: begin mn = 'h8200;  mx = 'h8800;  cs = 30000; af = 1; end
        default: begin
          mn = $urandom_range(1500);
          mx = mn + $urandom_range(2500);
          cs = $urandom_range(32768);
          af = $urandom_range(1);
        end
      endcase
      cfg_write(CFG_MIN_DIST, mn[15:0]);
      cfg_write(CFG_MAX_DIST, mx[15:0]);
      cfg_write(CFG_COS_MAX, cs[15:0]);
      cfg_write(CFG_AROM_FIRST, af[15:0]);
      case (s / 2)
        0: begin in_idle_pct = 27; out_idle_pct = 45; end
        1: begin in_idle_pct = 45; out_idle_pct = 27; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (k = 0; k < 340; k++) pending_pairs.push_back(random_pair());
      // pause the sender mid-stream until the pipeline is empty
      while (pending_pairs.size() > 170) @(posedge clk);
      hold_in = 1'b1;
      while (in_tvalid || expected_results.size() != 0) @(posedge clk);
      hold_in = 1'b0;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* cation_pi_geometry_check.f */
src/cpg_pkg.sv
src/cpg_mul.sv
src/cation_pi_geometry_check.sv
tb/tb_cation_pi_geometry_check.sv
